FILE: src/swstat_pkg.sv
// Shared types and constants for the sliding window statistics block.
// No dependencies.
package swstat_pkg;

    localparam int NUM_CH     = 3;
    localparam int WIN_FLOOR  = 10;
    localparam logic [10:0] WIN_RESET = 11'd500;

    localparam logic       OP_PUSH  = 1'b0;
    localparam logic       OP_CLEAR = 1'b1;
    localparam logic [1:0] CH_NONE  = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [1:0]         channel;
        logic signed [23:0] sample_value;
    } t_in_word;

    typedef struct packed {
        logic [10:0]        sample_count;
        logic signed [23:0] window_average;
        logic signed [23:0] window_minimum;
        logic signed [23:0] window_maximum;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_PUT
    } t_state;

endpackage

FILE: src/swstat_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
module swstat_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/swstat_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero. No dependencies.
module swstat_div #(
    parameter int DW = 35,
    parameter int VW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_mag;
    logic [VW:0]     r_rem;
    logic [VW-1:0]   r_div;
    logic            r_neg;
    logic [VW:0]     trial;
    logic            qbit;

    assign trial = {r_rem[VW-1:0], r_mag[DW-1]};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_mag <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? (trial - {1'b0, r_div}) : trial;
            r_mag <= {r_mag[DW-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

FILE: src/sliding_window_stats.sv
// Top level of the sliding window statistics block: ring control, scan, output.
// Depends on swstat_pkg, swstat_ram, swstat_div.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------
//  input   | i_in_valid  | o_in_stall   | i_in_word  (t_in_word)
//  output  | o_out_valid | i_out_stall  | o_out_word (t_out_word)
//  config  | i_cfg_we    | -            | i_cfg_wdata
//
// A push scans its channel's n held samples (one RAM read per cycle), then
// runs the divider and posts the word in ST_PUT; the next word is taken once
// the state is back in ST_IDLE. Clear and the empty channel code go straight
// to ST_PUT and post an all-zero word.
// Reset is synchronous; no clearing pass, the ring is read only where written.
// A stalled output word holds; a new item is accepted while it waits.
module sliding_window_stats
    import swstat_pkg::*;
#(
    parameter int WINDOW_MAX = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int WW  = (CW > 11) ? CW : 11;
    localparam int MW  = $clog2(NUM_CH * WINDOW_MAX);
    localparam int SW  = 24 + CW;

    t_state r_state, n_state;

    logic [AW-1:0] r_wpos [NUM_CH];
    logic [CW-1:0] r_fill [NUM_CH];
    logic [10:0]   r_win_cfg;

    logic [CW-1:0]        r_n, r_iss, r_rcv;
    logic [MW-1:0]        r_base;
    logic [AW-1:0]        r_idx;
    logic                 r_rd_pend;
    logic signed [SW-1:0] r_sum;
    logic signed [23:0]   r_lo, r_hi;
    t_out_word            r_res;
    logic                 r_out_valid;
    t_out_word            r_out;

    // effective window, clamped
    logic [WW-1:0] cfg_ext;
    logic [CW-1:0] eff_win;
    assign cfg_ext = WW'(r_win_cfg);
    always_comb begin
        if (cfg_ext < WW'(WIN_FLOOR)) begin
            eff_win = CW'(WIN_FLOOR);
        end else if (cfg_ext > WW'(WINDOW_MAX)) begin
            eff_win = CW'(WINDOW_MAX);
        end else begin
            eff_win = cfg_ext[CW-1:0];
        end
    end

    logic accept, out_free, is_push;
    logic [CW-1:0] fill_cl [NUM_CH];
    logic [AW-1:0] cur_pos, pos_next, idx_prev;
    logic [CW-1:0] fill_new;
    logic [MW-1:0] ch_base, waddr, raddr;
    logic [23:0]   rdata;
    logic signed [23:0] rval;
    logic          issue, last_rcv;
    logic          div_start, div_done;
    logic signed [SW-1:0] quot;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_push  = (i_in_word.operation == OP_PUSH) && (i_in_word.channel != CH_NONE);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            fill_cl[c] = (r_fill[c] > eff_win) ? eff_win : r_fill[c];
        end
    end

    assign cur_pos  = r_wpos[i_in_word.channel];
    assign pos_next = (cur_pos == AW'(WINDOW_MAX - 1)) ? '0 : cur_pos + 1'b1;
    assign fill_new = (fill_cl[i_in_word.channel] < eff_win)
                    ? fill_cl[i_in_word.channel] + 1'b1 : fill_cl[i_in_word.channel];
    assign ch_base  = MW'(i_in_word.channel) * MW'(WINDOW_MAX);
    assign waddr    = ch_base + MW'(cur_pos);

    assign idx_prev = (r_idx == '0) ? AW'(WINDOW_MAX - 1) : r_idx - 1'b1;
    assign raddr    = r_base + MW'(idx_prev);
    assign issue    = (r_state == ST_SCAN) && (r_iss != r_n);
    assign rval     = $signed(rdata);
    assign last_rcv = r_rd_pend && (r_rcv + 1'b1 == r_n);
    assign div_start = last_rcv;

    swstat_ram #(
        .WIDTH (24),
        .DEPTH (NUM_CH * WINDOW_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && is_push),
        .i_waddr (waddr),
        .i_wdata (i_in_word.sample_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    swstat_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum + SW'(rval)),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = is_push ? ST_SCAN : ST_PUT;
                end
            end
            ST_SCAN: begin
                if (last_rcv) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg   <= WIN_RESET;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_wpos[c] <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_win_cfg <= i_cfg_wdata;
            end
            r_rd_pend <= issue;
            if (accept) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_fill[c] <= fill_cl[c];
                end
                if (i_in_word.operation == OP_CLEAR) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_wpos[c] <= '0;
                        r_fill[c] <= '0;
                    end
                end else if (is_push) begin
                    r_wpos[i_in_word.channel] <= pos_next;
                    r_fill[i_in_word.channel] <= fill_new;
                end
            end
            if (r_state == ST_PUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res  <= '0;
            r_n    <= fill_new;
            r_base <= ch_base;
            r_idx  <= pos_next;
            r_iss  <= '0;
            r_rcv  <= '0;
            r_sum  <= '0;
            r_lo   <= i_in_word.sample_value;
            r_hi   <= i_in_word.sample_value;
        end else begin
            if (issue) begin
                r_idx <= idx_prev;
                r_iss <= r_iss + 1'b1;
            end
            if (r_rd_pend) begin
                r_rcv <= r_rcv + 1'b1;
                r_sum <= r_sum + SW'(rval);
                if (rval < r_lo) begin
                    r_lo <= rval;
                end
                if (rval > r_hi) begin
                    r_hi <= rval;
                end
            end
            if (div_done) begin
                r_res.sample_count   <= 11'(r_n);
                r_res.window_average <= quot[23:0];
                r_res.window_minimum <= r_lo;
                r_res.window_maximum <= r_hi;
            end
        end
        if (r_state == ST_PUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_iss <= r_n && r_rcv <= r_iss))
        else $error("scan counters out of order");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.sample_count == 11'd0) |->
        (o_out_word.window_average == 24'sd0 && o_out_word.window_minimum == 24'sd0
         && o_out_word.window_maximum == 24'sd0))
        else $error("empty result with nonzero statistics");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

endmodule

FILE: sim/swstat_checker.sv
// Checker for sliding_window_stats: watches the input, output and register ports,
// predicts each result word and compares it. Depends on swstat_pkg.
module swstat_checker
    import swstat_pkg::*;
#(
    parameter int WINDOW_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [23:0] ring_mem [NUM_CH][WINDOW_MAX];
    int unsigned        wr_pos [NUM_CH];
    int unsigned        held [NUM_CH];
    logic [10:0]        win_reg;
    t_out_word          stats_q [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = stats_q.size();

    function automatic int unsigned clamp_window();
        int unsigned w;
        w = win_reg;
        if (w < WIN_FLOOR) w = WIN_FLOOR;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    function automatic t_out_word window_stats(t_in_word w);
        t_out_word          r;
        int unsigned        win, ch, n, idx;
        longint             sum;
        logic signed [23:0] lo, hi, v;
        win = clamp_window();
        r   = '0;
        for (int c = 0; c < NUM_CH; c++)
            if (held[c] > win) held[c] = win;
        if (w.operation == OP_CLEAR) begin
            for (int c = 0; c < NUM_CH; c++) begin
                held[c]   = 0;
                wr_pos[c] = 0;
            end
            return r;
        end
        if (w.channel == CH_NONE) return r;
        ch = w.channel;
        ring_mem[ch][wr_pos[ch]] = w.sample_value;
        wr_pos[ch] = (wr_pos[ch] + 1) % WINDOW_MAX;
        if (held[ch] < win) held[ch]++;
        n   = held[ch];
        sum = 0;
        lo  = w.sample_value;
        hi  = w.sample_value;
        idx = wr_pos[ch];
        for (int k = 0; k < n; k++) begin
            idx = (idx == 0) ? WINDOW_MAX - 1 : idx - 1;
            v   = ring_mem[ch][idx];
            sum += v;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        r.sample_count   = 11'(n);
        r.window_average = 24'(sum / longint'(n));
        r.window_minimum = lo;
        r.window_maximum = hi;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                held[c]   = 0;
                wr_pos[c] = 0;
            end
            win_reg = WIN_RESET;
            stats_q.delete();
        end else begin
            if (i_cfg_we) win_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) stats_q.push_back(window_stats(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (stats_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word %h", $time, i_out_word);
                end else begin
                    exp_w = stats_q.pop_front();
                    if (exp_w.sample_count !== i_out_word.sample_count) begin
                        fails++;
                        $display("%0t: count exp %0d got %0d", $time,
                                 exp_w.sample_count, i_out_word.sample_count);
                    end
                    if (exp_w.window_average !== i_out_word.window_average) begin
                        fails++;
                        $display("%0t: average exp %0d got %0d", $time,
                                 exp_w.window_average, i_out_word.window_average);
                    end
                    if (exp_w.window_minimum !== i_out_word.window_minimum) begin
                        fails++;
                        $display("%0t: minimum exp %0d got %0d", $time,
                                 exp_w.window_minimum, i_out_word.window_minimum);
                    end
                    if (exp_w.window_maximum !== i_out_word.window_maximum) begin
                        fails++;
                        $display("%0t: maximum exp %0d got %0d", $time,
                                 exp_w.window_maximum, i_out_word.window_maximum);
                    end
                end
            end
        end
    end

    initial fails = 0;

    final begin
    end
endmodule

FILE: sim/tb_top.sv
// Testbench top for sliding_window_stats: clock, reset, stimulus and verdict.
// Depends on swstat_pkg, the block's RTL and swstat_checker.
module tb_top;
    import swstat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX     = 1024;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    int          fail_count, pending;
    int          cycles = 0;
    int          burst_left = 0;
    int          n_push = 0, n_clear = 0, n_none = 0, n_cfg = 0;
    int          stall_mode = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sliding_window_stats #(.WINDOW_MAX(WIN_MAX)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    swstat_checker #(.WINDOW_MAX(WIN_MAX)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stall pattern: the mode is drawn at random from four patterns
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 150 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(t_in_word w);
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        if (w.operation == OP_CLEAR) n_clear++;
        else if (w.channel == CH_NONE) n_none++;
        else n_push++;
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    task automatic push_sample(logic [1:0] ch, logic signed [23:0] v);
        send_word('{operation: OP_PUSH, channel: ch, sample_value: v});
    endtask

    // hold off until every result word has come back, then let the block settle
    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_window(logic [10:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        w.operation = OP_PUSH;
        w.channel   = 2'($urandom_range(0, 2));
        pick        = $urandom_range(0, 99);
        if (pick < 3) w.operation = OP_CLEAR;
        if (pick >= 3 && pick < 7) w.channel = CH_NONE;
        w.sample_value = 24'($urandom);
        if (w.channel == 2'd2 && $urandom_range(0, 1))
            w.sample_value = 24'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0)
            w.sample_value = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        if ($urandom_range(0, 15) == 0) w.operation = 1'($urandom_range(0, 1));
        return w;
    endfunction

    initial begin
        int win;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every channel, empty channel code, clear
        push_sample(2'd0, 24'sh7FFFFF);
        push_sample(2'd0, 24'sh800000);
        push_sample(2'd0, 24'sh000000);
        push_sample(2'd0, -24'sd1);
        push_sample(2'd1, -24'sd3);
        push_sample(2'd1, 24'sd2);
        push_sample(2'd2, 24'sd255);
        push_sample(2'd2, 24'sd0);
        push_sample(2'd2, 24'sd128);
        send_word('{operation: OP_PUSH, channel: CH_NONE, sample_value: 24'sh7FFFFF});
        send_word('{operation: OP_CLEAR, channel: 2'd0, sample_value: 24'sh800000});
        push_sample(2'd1, 24'sh800000);
        push_sample(2'd1, 24'sh800000);
        send_word('{operation: OP_CLEAR, channel: CH_NONE, sample_value: 24'sh7FFFFF});
        for (int i = 0; i < 12; i++) push_sample(2'd0, 24'($urandom));
        drain();

        // floor clamp shrinks the 12 held samples down to ten
        write_window(11'd0);
        for (int i = 0; i < 4; i++) push_sample(2'd0, 24'($urandom));
        drain();
        // growth does not bring dropped samples back
        write_window(11'd30);
        for (int i = 0; i < 4; i++) push_sample(2'd0, 24'($urandom));
        drain();
        write_window(11'd2047);
        for (int i = 0; i < 6; i++) push_sample(2'd1, 24'($urandom));
        drain();
        write_window(11'd1024);
        for (int i = 0; i < 4; i++) push_sample(2'd2, 24'($urandom));
        drain();

        // random phases, mostly small windows to keep the scans short
        for (int p = 0; p < 12; p++) begin
            case ($urandom_range(0, 5))
                0: win = $urandom_range(0, 2047);
                1: win = 10;
                default: win = $urandom_range(9, 40);
            endcase
            write_window(11'(win));
            for (int i = 0; i < 45; i++) send_word(random_word());
            drain();
        end

        $display("Covered %0d pushes, %0d clears, %0d empty-channel words, %0d window writes.",
                 n_push, n_clear, n_none, n_cfg);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: sliding_window_stats.f
src/swstat_pkg.sv
src/swstat_ram.sv
src/swstat_div.sv
src/sliding_window_stats.sv
sim/swstat_checker.sv
sim/tb_top.sv
